// File: sv/usbreq_pkg.sv
// Shared types and constants for the USB standard request decoder.
// Holds request, descriptor and register codes plus the setup and result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usbreq_pkg;

  // Endpoints with a halt bit, and string descriptors that can be served.
  localparam int ENDPOINT_COUNT = 8;
  localparam int STRING_COUNT   = 4;
  localparam int HALT_WIDTH     = 8;
  localparam int MAX_STRINGS    = 4;

  // bRequest codes.
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_RESERVED_2        = 8'd2;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_RESERVED_4        = 8'd4;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_SET_DESCRIPTOR    = 8'd7;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  // bmRequestType values.
  localparam logic [7:0] RT_STATUS_DEVICE    = 8'h80;
  localparam logic [7:0] RT_STATUS_INTERFACE = 8'h81;
  localparam logic [7:0] RT_STATUS_ENDPOINT  = 8'h82;
  localparam logic [7:0] RT_FEATURE_DEVICE   = 8'h00;
  localparam logic [7:0] RT_FEATURE_ENDPOINT = 8'h02;

  // Descriptor types and other wValue / wIndex constants.
  localparam logic [7:0]  DT_DEVICE        = 8'd1;
  localparam logic [7:0]  DT_CONFIGURATION = 8'd2;
  localparam logic [7:0]  DT_STRING        = 8'd3;
  localparam logic [15:0] FEAT_ENDPOINT_HALT = 16'h0000;
  localparam logic [15:0] LANG_ID_NONE       = 16'h0000;
  localparam logic [15:0] LANG_ID_EN_US      = 16'h0409;
  localparam logic [6:0]  EP_NUM_MASK        = 7'h7F;
  localparam int          TOGGLE_EP          = 2;

  // descriptor_select codes.
  localparam logic [2:0] SEL_NONE     = 3'd0;
  localparam logic [2:0] SEL_DEVICE   = 3'd1;
  localparam logic [2:0] SEL_CONFIG   = 3'd2;
  localparam logic [2:0] SEL_LANGUAGE = 3'd3;

  // Reply lengths.
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_BYTE  = 2'd1;
  localparam logic [1:0] LEN_WORD  = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic CFG_CONFIGURATION_VALUE = 1'b0;
  localparam logic CFG_INTERFACE_NUMBER    = 1'b1;
  localparam logic [7:0] CONFIGURATION_VALUE_RST = 8'd1;
  localparam logic [7:0] INTERFACE_NUMBER_RST    = 8'd0;

  typedef struct packed {
    logic [7:0]  request_type_byte;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
  } setup_t;

  typedef struct packed {
    logic       stall_control;
    logic [1:0] reply_length;
    logic [7:0] reply_first;
    logic [7:0] reply_second;
    logic [2:0] descriptor_select;
    logic       toggle_reset;
  } result_t;

  typedef struct packed {
    logic [HALT_WIDTH-1:0] in_bits;
    logic [HALT_WIDTH-1:0] out_bits;
  } halt_t;

  typedef struct packed {
    logic [7:0] configuration_value;
    logic [7:0] interface_number;
  } cfg_regs_t;

endpackage

`default_nettype wire

// File: sv/usbreq_state.sv
// Configuration registers and endpoint halt bits of the request decoder.
// Depends on usbreq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbreq_state
  import usbreq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       halt_upd,
  input  wire halt_t      halt_nxt,
  output cfg_regs_t       regs,
  output halt_t           halt
);

  cfg_regs_t regs_r;
  halt_t     halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.configuration_value <= CONFIGURATION_VALUE_RST;
      regs_r.interface_number    <= INTERFACE_NUMBER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONFIGURATION_VALUE: regs_r.configuration_value <= cfg_data;
        CFG_INTERFACE_NUMBER:    regs_r.interface_number    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r <= '0;
    end else if (halt_upd) begin
      halt_r <= halt_nxt;
    end
  end

  assign regs = regs_r;
  assign halt = halt_r;

endmodule

`default_nettype wire

// File: sv/usbreq_decode.sv
// Combinational decode of one setup packet into a result and new halt bits.
// Depends on usbreq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbreq_decode
  import usbreq_pkg::*;
#(
  parameter int EP_COUNT  = ENDPOINT_COUNT,
  parameter int STR_COUNT = STRING_COUNT
)
(
  input  wire setup_t    setup,
  input  wire cfg_regs_t regs,
  input  wire halt_t     halt,
  output result_t        result,
  output halt_t          halt_nxt
);

  logic [6:0]            ep_num;
  logic                  ep_valid;
  logic                  ep_is_in;
  logic [HALT_WIDTH-1:0] ep_mask;
  logic [7:0]            desc_type;
  logic [7:0]            desc_idx;
  logic                  str_ok;

  always_comb begin
    ep_num   = setup.index_word[6:0] & EP_NUM_MASK;
    ep_valid = (32'(ep_num) < EP_COUNT) && (32'(ep_num) < HALT_WIDTH);
    ep_is_in = (ep_num == 7'd0) || setup.index_word[7];
    ep_mask  = HALT_WIDTH'(1) << ep_num[$clog2(HALT_WIDTH)-1:0];
    desc_type = setup.value_word[15:8];
    desc_idx  = setup.value_word[7:0];
    str_ok   = (desc_idx >= 8'd1) && (32'(desc_idx) <= STR_COUNT)
               && (32'(desc_idx) <= MAX_STRINGS);
  end

  always_comb begin
    result   = '0;
    halt_nxt = halt;
    case (setup.request_code)
      REQ_GET_STATUS: begin
        if (setup.request_type_byte == RT_STATUS_DEVICE ||
            setup.request_type_byte == RT_STATUS_INTERFACE) begin
          result.reply_length = LEN_WORD;
        end else if (setup.request_type_byte == RT_STATUS_ENDPOINT && ep_valid) begin
          result.reply_length = LEN_WORD;
          result.reply_first  = {7'd0, |((ep_is_in ? halt.in_bits : halt.out_bits)
                                         & ep_mask)};
        end else begin
          result.stall_control = 1'b1;
        end
      end
      REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
        if (setup.request_type_byte == RT_FEATURE_DEVICE) begin
          // Clearing a device feature is refused; setting one is a no-op.
          result.stall_control = (setup.request_code == REQ_CLEAR_FEATURE);
        end else if (setup.request_type_byte == RT_FEATURE_ENDPOINT) begin
          if (setup.value_word != FEAT_ENDPOINT_HALT || !ep_valid) begin
            result.stall_control = 1'b1;
          end else if (setup.request_code == REQ_CLEAR_FEATURE) begin
            if (ep_is_in) halt_nxt.in_bits  = halt.in_bits & ~ep_mask;
            else          halt_nxt.out_bits = halt.out_bits & ~ep_mask;
          end else begin
            if (ep_is_in) halt_nxt.in_bits  = halt.in_bits | ep_mask;
            else          halt_nxt.out_bits = halt.out_bits | ep_mask;
          end
        end
      end
      REQ_RESERVED_2, REQ_RESERVED_4, REQ_SET_DESCRIPTOR: begin
        result.stall_control = 1'b1;
      end
      REQ_GET_DESCRIPTOR: begin
        if (desc_type == DT_DEVICE) begin
          result.descriptor_select = SEL_DEVICE;
        end else if (desc_type == DT_CONFIGURATION) begin
          result.descriptor_select = SEL_CONFIG;
        end else if (desc_type == DT_STRING) begin
          if (setup.index_word == LANG_ID_NONE) begin
            result.descriptor_select = SEL_LANGUAGE;
          end else if (setup.index_word == LANG_ID_EN_US && str_ok) begin
            result.descriptor_select = SEL_LANGUAGE + desc_idx[2:0];
          end else begin
            result.stall_control = 1'b1;
          end
        end else begin
          result.stall_control = 1'b1;
        end
      end
      REQ_GET_CONFIGURATION: begin
        result.reply_length = LEN_BYTE;
        result.reply_first  = regs.configuration_value;
      end
      REQ_GET_INTERFACE: begin
        result.reply_length = LEN_BYTE;
        result.reply_first  = regs.interface_number;
      end
      REQ_SET_INTERFACE: begin
        result.toggle_reset = 1'b1;
        halt_nxt.in_bits[TOGGLE_EP]  = 1'b0;
        halt_nxt.out_bits[TOGGLE_EP] = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/usb_standard_request_decoder_top.sv
// Top level of the USB standard request decoder.
// Depends on usbreq_pkg, usbreq_state and usbreq_decode.
//
// Usage:
//   A setup packet is transferred on the in_ channel (in_valid / in_ready).
//   Exactly one result is transferred on the out_ channel for each packet,
//   in order (out_valid / out_ready).
//   The cfg_ port writes configuration_value (index 0) or interface_number
//   (index 1) on any clock edge with cfg_we high; write only while idle.
//   A packet is captured in the input register, decoded, and its result is
//   then registered in the output register.
//   Throughput: one packet per cycle while the receiver takes results; the halt
//   bits are updated as a packet moves from the input register to the output
//   register, so the next packet already sees them.
//   When the receiver stalls, the output register holds its result and the
//   input register holds the following packet; in_ready then drops.
//   Reset (rst_n low, synchronous) empties both registers, clears all halt
//   bits, sets configuration_value to 1 and interface_number to 0.
`timescale 1ns / 1ps
`default_nettype none

module usb_standard_request_decoder_top
  import usbreq_pkg::*;
#(
  parameter int EP_COUNT  = ENDPOINT_COUNT,
  parameter int STR_COUNT = STRING_COUNT
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_request_type_byte,
  input  wire logic [7:0]  in_request_code,
  input  wire logic [15:0] in_value_word,
  input  wire logic [15:0] in_index_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_stall_control,
  output logic [1:0]       out_reply_length,
  output logic [7:0]       out_reply_first,
  output logic [7:0]       out_reply_second,
  output logic [2:0]       out_descriptor_select,
  output logic             out_toggle_reset,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic      s1_valid_r;
  setup_t    s1_setup_r;
  logic      out_valid_r;
  result_t   out_result_r;
  logic      advance;
  result_t   result;
  halt_t     halt;
  halt_t     halt_nxt;
  cfg_regs_t regs;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_setup_r.request_type_byte <= in_request_type_byte;
      s1_setup_r.request_code      <= in_request_code;
      s1_setup_r.value_word        <= in_value_word;
      s1_setup_r.index_word        <= in_index_word;
    end
  end

  usbreq_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .halt_upd (advance),
    .halt_nxt (halt_nxt),
    .regs     (regs),
    .halt     (halt)
  );

  usbreq_decode #(
    .EP_COUNT (EP_COUNT),
    .STR_COUNT(STR_COUNT)
  ) u_decode (
    .setup   (s1_setup_r),
    .regs    (regs),
    .halt    (halt),
    .result  (result),
    .halt_nxt(halt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= result;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_stall_control     = out_result_r.stall_control;
  assign out_reply_length      = out_result_r.reply_length;
  assign out_reply_first       = out_result_r.reply_first;
  assign out_reply_second      = out_result_r.reply_second;
  assign out_descriptor_select = out_result_r.descriptor_select;
  assign out_toggle_reset      = out_result_r.toggle_reset;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for usb_standard_request_decoder_top: it sends setup packets and
// predicts each reply, including the endpoint halt bits, then compares every reply field.
// Depends on usbreq_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import usbreq_pkg::*;

  // Request codes and a recipient that the package does not name.
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_SYNCH_FRAME       = 8'd12;
  localparam logic [7:0] RT_FEATURE_INTERFACE  = 8'h01;
  localparam int STUCK_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_request_type_byte = '0;
  logic [7:0]  in_request_code = '0;
  logic [15:0] in_value_word = '0;
  logic [15:0] in_index_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_stall_control;
  logic [1:0]  out_reply_length;
  logic [7:0]  out_reply_first;
  logic [7:0]  out_reply_second;
  logic [2:0]  out_descriptor_select;
  logic        out_toggle_reset;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  // Our own copy of the block's state and registers.
  logic [HALT_WIDTH-1:0] ep_in_halt;
  logic [HALT_WIDTH-1:0] ep_out_halt;
  logic [7:0] cfg_config_value;
  logic [7:0] cfg_interface_num;

  result_t pending_replies[$];

  int error_count = 0;
  int items_sent = 0;
  int replies_checked = 0;
  int stalls_seen = 0;
  int descriptors_seen = 0;
  int toggles_seen = 0;
  int reg_writes = 0;
  int stuck_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int rx_mode_left = 0;
  int rx_period = 3;
  int rx_phase = 0;

  usb_standard_request_decoder_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_request_type_byte (in_request_type_byte),
    .in_request_code      (in_request_code),
    .in_value_word        (in_value_word),
    .in_index_word        (in_index_word),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_stall_control    (out_stall_control),
    .out_reply_length     (out_reply_length),
    .out_reply_first      (out_reply_first),
    .out_reply_second     (out_reply_second),
    .out_descriptor_select(out_descriptor_select),
    .out_toggle_reset     (out_toggle_reset),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // An endpoint is known when its number fits both the endpoint count and the halt state.
  // Endpoint zero always uses the IN halt bit.
  function automatic logic endpoint_lookup(input logic [7:0] addr, output logic [7:0] mask,
                                           output logic is_in);
    logic [6:0] num;
    num = addr[6:0] & EP_NUM_MASK;
    mask = '0;
    is_in = 1'b0;
    if (num >= ENDPOINT_COUNT || num >= HALT_WIDTH) return 1'b0;
    mask = 8'(1) << num;
    is_in = (num == 0) || addr[7];
    return 1'b1;
  endfunction

  // Works out the reply to one setup packet and applies its effect on the halt bits.
  function automatic result_t decode_request(input setup_t s);
    result_t r;
    logic [7:0] mask;
    logic is_in;
    logic [7:0] dtype;
    logic [7:0] didx;
    r = '0;
    dtype = s.value_word[15:8];
    didx = s.value_word[7:0];
    case (s.request_code)
      REQ_GET_STATUS: begin
        if (s.request_type_byte == RT_STATUS_DEVICE ||
            s.request_type_byte == RT_STATUS_INTERFACE) begin
          r.reply_length = LEN_WORD;
        end else if (s.request_type_byte == RT_STATUS_ENDPOINT &&
                     endpoint_lookup(s.index_word[7:0], mask, is_in)) begin
          r.reply_first = {7'd0, |((is_in ? ep_in_halt : ep_out_halt) & mask)};
          r.reply_length = LEN_WORD;
        end else begin
          r.stall_control = 1'b1;
        end
      end
      REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
        if (s.request_type_byte == RT_FEATURE_DEVICE) begin
          r.stall_control = (s.request_code == REQ_CLEAR_FEATURE);
        end else if (s.request_type_byte == RT_FEATURE_ENDPOINT) begin
          if (s.value_word != FEAT_ENDPOINT_HALT ||
              !endpoint_lookup(s.index_word[7:0], mask, is_in)) begin
            r.stall_control = 1'b1;
          end else if (s.request_code == REQ_CLEAR_FEATURE) begin
            if (is_in) ep_in_halt &= ~mask;
            else ep_out_halt &= ~mask;
          end else begin
            if (is_in) ep_in_halt |= mask;
            else ep_out_halt |= mask;
          end
        end
      end
      REQ_RESERVED_2, REQ_RESERVED_4, REQ_SET_DESCRIPTOR: begin
        r.stall_control = 1'b1;
      end
      REQ_GET_DESCRIPTOR: begin
        if (dtype == DT_DEVICE) begin
          r.descriptor_select = SEL_DEVICE;
        end else if (dtype == DT_CONFIGURATION) begin
          r.descriptor_select = SEL_CONFIG;
        end else if (dtype == DT_STRING && s.index_word == LANG_ID_NONE) begin
          r.descriptor_select = SEL_LANGUAGE;
        end else if (dtype == DT_STRING && s.index_word == LANG_ID_EN_US && didx >= 1 &&
                     didx <= STRING_COUNT && didx <= MAX_STRINGS) begin
          r.descriptor_select = 3'(SEL_LANGUAGE + didx);
        end else begin
          r.stall_control = 1'b1;
        end
      end
      REQ_GET_CONFIGURATION: begin
        r.reply_length = LEN_BYTE;
        r.reply_first = cfg_config_value;
      end
      REQ_GET_INTERFACE: begin
        r.reply_length = LEN_BYTE;
        r.reply_first = cfg_interface_num;
      end
      REQ_SET_INTERFACE: begin
        r.toggle_reset = 1'b1;
        ep_in_halt[TOGGLE_EP] = 1'b0;
        ep_out_halt[TOGGLE_EP] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_reply(input result_t got);
    result_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch("reply with no request pending", 32'(got), 32'd0);
      return;
    end
    want = pending_replies.pop_front();
    if (got.stall_control !== want.stall_control)
      report_mismatch("stall_control", 32'(got.stall_control), 32'(want.stall_control));
    if (got.reply_length !== want.reply_length)
      report_mismatch("reply_length", 32'(got.reply_length), 32'(want.reply_length));
    if (got.reply_first !== want.reply_first)
      report_mismatch("reply_first", 32'(got.reply_first), 32'(want.reply_first));
    if (got.reply_second !== want.reply_second)
      report_mismatch("reply_second", 32'(got.reply_second), 32'(want.reply_second));
    if (got.descriptor_select !== want.descriptor_select)
      report_mismatch("descriptor_select", 32'(got.descriptor_select),
                      32'(want.descriptor_select));
    if (got.toggle_reset !== want.toggle_reset)
      report_mismatch("toggle_reset", 32'(got.toggle_reset), 32'(want.toggle_reset));
    replies_checked++;
    if (want.stall_control) stalls_seen++;
    if (want.descriptor_select != SEL_NONE) descriptors_seen++;
    if (want.toggle_reset) toggles_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      check_reply({out_stall_control, out_reply_length, out_reply_first, out_reply_second,
                   out_descriptor_select, out_toggle_reset});
  end

  // Receiver: switches between always ready, random stalls and a periodic pattern.
  // A long hold requested by a test overrides all of them.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_period = $urandom_range(2, 7);
        rx_mode_left = $urandom_range(16, 80);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= (rx_phase % rx_period) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Offers one setup packet and returns at the edge where its transfer happens. Valid is
  // left high so that a following packet can go out on the next cycle.
  task automatic send_setup(input logic [7:0] rtype, input logic [7:0] code,
                            input logic [15:0] value, input logic [15:0] index);
    setup_t pkt;
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    pkt.request_type_byte = rtype;
    pkt.request_code = code;
    pkt.value_word = value;
    pkt.index_word = index;
    in_valid <= 1'b1;
    in_request_type_byte <= rtype;
    in_request_code <= code;
    in_value_word <= value;
    in_index_word <= index;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_replies.push_back(decode_request(pkt));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_registers(input logic [7:0] config_value, input logic [7:0] iface);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_CONFIGURATION_VALUE;
    cfg_data <= config_value;
    @(posedge clk);
    cfg_config_value = config_value;
    cfg_index <= CFG_INTERFACE_NUMBER;
    cfg_data <= iface;
    @(posedge clk);
    cfg_interface_num = iface;
    cfg_we <= 1'b0;
    reg_writes += 2;
    @(posedge clk);
  endtask

  function automatic logic [7:0] random_endpoint();
    if ($urandom_range(0, 3) != 0)
      return {1'($urandom_range(0, 1)), 4'd0, 3'($urandom_range(0, 7))};
    return 8'($urandom);
  endfunction

  // Mostly well-formed requests with random content; the rest is plain noise.
  function automatic setup_t random_setup();
    setup_t s;
    int pick;
    s.request_type_byte = 8'($urandom);
    s.request_code = 8'($urandom);
    s.value_word = 16'($urandom);
    s.index_word = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      s.request_code = REQ_GET_STATUS;
      case ($urandom_range(0, 4))
        0: s.request_type_byte = RT_STATUS_DEVICE;
        1: s.request_type_byte = RT_STATUS_INTERFACE;
        2, 3: s.request_type_byte = RT_STATUS_ENDPOINT;
        default: ;
      endcase
      s.index_word[7:0] = random_endpoint();
    end else if (pick < 46) begin
      s.request_code = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
      case ($urandom_range(0, 5))
        0: s.request_type_byte = RT_FEATURE_DEVICE;
        1, 2, 3: s.request_type_byte = RT_FEATURE_ENDPOINT;
        4: s.request_type_byte = RT_FEATURE_INTERFACE;
        default: ;
      endcase
      if ($urandom_range(0, 6) != 0) s.value_word = FEAT_ENDPOINT_HALT;
      s.index_word[7:0] = random_endpoint();
    end else if (pick < 66) begin
      s.request_code = REQ_GET_DESCRIPTOR;
      case ($urandom_range(0, 5))
        0: s.value_word[15:8] = DT_DEVICE;
        1: s.value_word[15:8] = DT_CONFIGURATION;
        2, 3, 4: s.value_word[15:8] = DT_STRING;
        default: ;
      endcase
      if ($urandom_range(0, 4) != 0) s.value_word[7:0] = 8'($urandom_range(0, 6));
      case ($urandom_range(0, 3))
        0: s.index_word = LANG_ID_NONE;
        1, 2: s.index_word = LANG_ID_EN_US;
        default: ;
      endcase
    end else if (pick < 74) begin
      s.request_code = $urandom_range(0, 1) ? REQ_GET_CONFIGURATION : REQ_GET_INTERFACE;
    end else if (pick < 80) begin
      s.request_code = REQ_SET_INTERFACE;
    end else if (pick < 88) begin
      case ($urandom_range(0, 6))
        0: s.request_code = REQ_RESERVED_2;
        1: s.request_code = REQ_RESERVED_4;
        2: s.request_code = REQ_SET_DESCRIPTOR;
        3: s.request_code = REQ_SET_ADDRESS;
        4: s.request_code = REQ_SET_CONFIGURATION;
        5: s.request_code = REQ_SYNCH_FRAME;
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic send_random(input int count);
    setup_t s;
    repeat (count) begin
      s = random_setup();
      send_setup(s.request_type_byte, s.request_code, s.value_word, s.index_word);
    end
  endtask

  task automatic test_reset_values();
    send_setup(8'h80, REQ_GET_CONFIGURATION, 16'h0000, 16'h0000);
    send_setup(8'h81, REQ_GET_INTERFACE, 16'h0000, 16'h0000);
    send_setup(RT_STATUS_DEVICE, REQ_GET_STATUS, 16'h0000, 16'h0000);
    send_setup(RT_STATUS_INTERFACE, REQ_GET_STATUS, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_endpoint_halt();
    send_setup(RT_FEATURE_ENDPOINT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 16'h0081);
    // Only the low byte of the index selects the endpoint.
    send_setup(RT_FEATURE_ENDPOINT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 16'hFF01);
    send_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 16'h0000, 16'h0081);
    // Endpoint zero shares one halt bit for both directions.
    send_setup(RT_FEATURE_ENDPOINT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 16'h0000);
    send_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 16'h0000, 16'h0080);
    send_setup(RT_FEATURE_ENDPOINT, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 16'h0080);
    send_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 16'h0000, 16'hFFFF);
    send_setup(RT_FEATURE_ENDPOINT, REQ_SET_FEATURE, 16'h0001, 16'h0002);
    send_setup(RT_FEATURE_DEVICE, REQ_CLEAR_FEATURE, 16'h0001, 16'h0000);
    send_setup(RT_FEATURE_DEVICE, REQ_SET_FEATURE, 16'h0001, 16'h0000);
    send_setup(RT_FEATURE_INTERFACE, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 16'h0081);
    send_setup(8'h00, REQ_GET_STATUS, 16'h0000, 16'h0000);
  endtask

  task automatic test_descriptors();
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, LANG_ID_NONE);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_CONFIGURATION, 8'h00}, LANG_ID_NONE);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h00}, LANG_ID_NONE);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h01}, LANG_ID_EN_US);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h04}, LANG_ID_EN_US);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h05}, LANG_ID_EN_US);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h01}, 16'h0407);
    send_setup(8'h80, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_set_interface();
    send_setup(RT_FEATURE_ENDPOINT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 16'h0082);
    send_setup(RT_FEATURE_ENDPOINT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 16'h0002);
    send_setup(8'h01, REQ_SET_INTERFACE, 16'h0000, 16'h0000);
    send_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 16'h0000, 16'h0082);
    send_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 16'h0000, 16'h0002);
  endtask

  task automatic test_other_codes();
    send_setup(8'h00, REQ_RESERVED_2, 16'h0000, 16'h0000);
    send_setup(8'h00, REQ_RESERVED_4, 16'h0000, 16'h0000);
    send_setup(8'h00, REQ_SET_DESCRIPTOR, 16'h0100, 16'h0000);
    send_setup(8'h00, REQ_SYNCH_FRAME, 16'h0000, 16'h0000);
    send_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_register_extremes();
    write_registers(8'h00, 8'hFF);
    send_setup(8'h80, REQ_GET_CONFIGURATION, 16'h0000, 16'h0000);
    send_setup(8'h81, REQ_GET_INTERFACE, 16'h0000, 16'h0000);
    write_registers(8'hFF, 8'h00);
    send_setup(8'h80, REQ_GET_CONFIGURATION, 16'h0000, 16'h0000);
    send_setup(8'h81, REQ_GET_INTERFACE, 16'h0000, 16'h0000);
  endtask

  // The receiver holds off long enough for the decoder to fill and stall its input.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 300;
    send_random(40);
    // The sender now pauses until every reply has come back.
    wait_idle();
    gaps_on = 1'b1;
    send_random(30);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_registers(8'h01, 8'h00);
        1: write_registers(8'hFF, 8'hFF);
        default: write_registers(8'($urandom), 8'($urandom));
      endcase
      // Every other phase runs with no gaps from the sender.
      gaps_on = phase[0];
      send_random(300);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    ep_in_halt = '0;
    ep_out_halt = '0;
    cfg_config_value = CONFIGURATION_VALUE_RST;
    cfg_interface_num = INTERFACE_NUMBER_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_endpoint_halt();
    test_descriptors();
    test_set_interface();
    test_other_codes();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d setup packets and checked %0d replies after %0d register writes;",
             items_sent, replies_checked, reg_writes);
    $display("%0d replies stalled, %0d served a descriptor, %0d reset the data toggles.",
             stalls_seen, descriptors_seen, toggles_seen);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
